@@ rtl/svpf_pkg.sv @@
// ----------------------------------------------------------------------------
// svpf_pkg
// Shared types, codes and constants for the swizzled VRAM blitter with
// page flipping.
// ----------------------------------------------------------------------------
`default_nettype none

package svpf_pkg;

    // VRAM size in bytes; flipping needs room for two frames
    localparam int unsigned VRAM_BYTES = 524288;

    // Field widths
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ADDR_W   = 20;
    localparam int unsigned START_W  = 16;
    localparam int unsigned STRIDE_W = 11;
    localparam int unsigned MROWS_W  = 9;
    localparam int unsigned IWIDTH_W = 10;
    localparam int unsigned IROWS_W  = 9;
    localparam int unsigned COL_W    = 11;
    localparam int unsigned ROW_W    = 9;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PIXEL  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FLIP   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MODE   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISPLAY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_PIXELS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VRAM_STRIDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_ROWS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd5;

    // Register reset values
    localparam logic [STRIDE_W-1:0] RST_VRAM_STRIDE = 11'd256;
    localparam logic [MROWS_W-1:0]  RST_MODE_ROWS   = 9'd240;
    localparam logic [IWIDTH_W-1:0] RST_IMAGE_WIDTH = 10'd256;
    localparam logic [IROWS_W-1:0]  RST_IMAGE_ROWS  = 9'd240;
    localparam logic [ADDR_W-1:0]   RST_FRAME_SIZE  = 20'd61440;

    typedef logic [ADDR_W-1:0] addr_t;

    // Bank swizzle: bit 2 moves to bit 18, bits 18..3 shift down by one
    function automatic addr_t swizzle(input addr_t off);
        swizzle = {1'b0, off[2], off[18:3], off[1:0]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/svpf_if.sv @@
// ----------------------------------------------------------------------------
// svpf_if
// Valid/ready channels of the blitter: image beats in, VRAM results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface svpf_in_if
    import svpf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   pixel_byte;

    modport source (output valid, output action, output pixel_byte, input ready);
    modport sink   (input valid, input action, input pixel_byte, output ready);
endinterface

interface svpf_out_if
    import svpf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  vram_address;
    logic [BYTE_W-1:0]  write_byte;
    logic [START_W-1:0] display_start;
    logic               image_done;

    modport source (output valid, output kind, output vram_address, output write_byte,
                    output display_start, output image_done, input ready);
    modport sink   (input valid, input kind, input vram_address, input write_byte,
                    input display_start, input image_done, output ready);
endinterface

`default_nettype wire

@@ rtl/swizzled_vram_blit_page_flip.sv @@
// ----------------------------------------------------------------------------
// swizzled_vram_blit_page_flip
// Image byte stream to VRAM byte writes, with page flip and mode start.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries beats of {action, pixel_byte}. A pixel beat yields one
//          VRAM write beat on out_ch (address, byte, last-byte-of-image mark).
//          A flip beat yields a display start update or a refusal; a mode
//          start beat yields a display start of zero. Action code 3 is
//          dropped without a result.
//   cfg_we/cfg_index/cfg_data write the six mode registers; write them only
//          while no beat is in flight.
//   Path: the accept edge loads the input register; the beat moves on into
//   the result register once that is free, and out_ch is driven from the
//   result register. Throughput is one beat per cycle while out_ch does
//   not stall; the frame size product is kept in a register loaded
//   together with the stride and row count, so the per-beat path is one
//   three-term 20-bit add, the counter compares and the swizzle.
//   Reset clears the page and image counters and loads the register
//   defaults. When out_ch stalls, the result register holds and the input
//   register fills; in_ch ready drops once both are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module swizzled_vram_blit_page_flip
    import svpf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    svpf_in_if.sink                    in_ch,
    svpf_out_if.source                 out_ch
);

    // Mode registers
    logic                linear_mode_reg;
    logic                wide_pixels_reg;
    logic [STRIDE_W-1:0] vram_stride_reg;
    logic [MROWS_W-1:0]  mode_rows_reg;
    logic [IWIDTH_W-1:0] image_width_reg;
    logic [IROWS_W-1:0]  image_rows_reg;
    addr_t               frame_size_reg;
    logic [STRIDE_W-1:0] vram_stride_next;
    logic [MROWS_W-1:0]  mode_rows_next;

    // Input register
    logic                in_valid_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [BYTE_W-1:0]   pixel_reg;

    // Page and image state
    logic             display_page_reg;
    logic             draw_page_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    addr_t            row_base_reg;

    // Result register
    logic               out_valid_reg;
    logic [KIND_W-1:0]  kind_reg;
    addr_t              addr_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic [START_W-1:0] start_reg;
    logic               done_reg;

    // Datapath
    logic             advance;
    logic             has_result;
    logic             flip_ok;
    logic [COL_W-1:0] span;
    addr_t            draw_off;
    addr_t            off;
    addr_t            pix_addr;
    logic [COL_W-1:0] col_inc;
    logic [ROW_W-1:0] row_inc;
    logic             row_wrap;
    logic             img_wrap;

    logic               display_page_next;
    logic               draw_page_next;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_next;
    addr_t              row_base_next;
    logic [KIND_W-1:0]  kind_next;
    addr_t              addr_next;
    logic [BYTE_W-1:0]  byte_next;
    logic [START_W-1:0] start_next;
    logic               done_next;

    // Stride and row count as they stand after this edge
    assign vram_stride_next = (cfg_we && (cfg_index == CFG_VRAM_STRIDE))
                              ? cfg_data[STRIDE_W-1:0] : vram_stride_reg;
    assign mode_rows_next   = (cfg_we && (cfg_index == CFG_MODE_ROWS))
                              ? cfg_data[MROWS_W-1:0] : mode_rows_reg;

    // Write mode registers; load the frame size product with them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_mode_reg <= 1'b0;
            wide_pixels_reg <= 1'b0;
            vram_stride_reg <= RST_VRAM_STRIDE;
            mode_rows_reg   <= RST_MODE_ROWS;
            image_width_reg <= RST_IMAGE_WIDTH;
            image_rows_reg  <= RST_IMAGE_ROWS;
            frame_size_reg  <= RST_FRAME_SIZE;
        end
        else
        begin
            frame_size_reg <= ADDR_W'(vram_stride_next * mode_rows_next);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LINEAR_MODE: linear_mode_reg <= cfg_data[0];
                    CFG_WIDE_PIXELS: wide_pixels_reg <= cfg_data[0];
                    CFG_VRAM_STRIDE: vram_stride_reg <= cfg_data[STRIDE_W-1:0];
                    CFG_MODE_ROWS:   mode_rows_reg   <= cfg_data[MROWS_W-1:0];
                    CFG_IMAGE_WIDTH: image_width_reg <= cfg_data[IWIDTH_W-1:0];
                    CFG_IMAGE_ROWS:  image_rows_reg  <= cfg_data[IROWS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Move the held beat on when the result register is free or it has no result
    assign has_result   = (action_reg != ACT_UNUSED);
    assign advance      = in_valid_reg && (!has_result || !out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;

    // Capture input beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            action_reg <= in_ch.action;
            pixel_reg  <= in_ch.pixel_byte;
        end
    end

    // Derived mode values
    assign flip_ok  = !linear_mode_reg
                      && ({1'b0, frame_size_reg, 1'b0} <= (ADDR_W+2)'(VRAM_BYTES));
    assign span     = wide_pixels_reg ? {image_width_reg, 1'b0} : {1'b0, image_width_reg};
    assign draw_off = draw_page_reg ? frame_size_reg : '0;

    // Pixel address and counter advance
    assign off      = draw_off + row_base_reg + ADDR_W'(col_reg);
    assign pix_addr = linear_mode_reg ? off : swizzle(off);
    assign col_inc  = col_reg + 1'b1;
    assign row_inc  = row_reg + 1'b1;
    assign row_wrap = (col_inc >= span);
    assign img_wrap = (row_inc >= image_rows_reg);

    // Decode the held beat
    always_comb
    begin
        display_page_next = display_page_reg;
        draw_page_next    = draw_page_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        row_base_next     = row_base_reg;
        kind_next         = KIND_WRITE;
        addr_next         = '0;
        byte_next         = '0;
        start_next        = '0;
        done_next         = 1'b0;
        case (action_reg)
            ACT_PIXEL:
            begin
                addr_next = pix_addr;
                byte_next = pixel_reg;
                col_next  = col_inc;
                if (row_wrap)
                begin
                    col_next      = '0;
                    row_next      = row_inc;
                    row_base_next = row_base_reg + ADDR_W'(vram_stride_reg);
                    if (img_wrap)
                    begin
                        row_next      = '0;
                        row_base_next = '0;
                        done_next     = 1'b1;
                    end
                end
            end
            ACT_FLIP:
            begin
                if (flip_ok)
                begin
                    kind_next         = KIND_DISPLAY;
                    display_page_next = draw_page_reg;
                    draw_page_next    = !draw_page_reg;
                    start_next        = draw_page_reg ? frame_size_reg[START_W+2:3] : '0;
                end
                else
                begin
                    kind_next = KIND_REFUSED;
                end
            end
            ACT_MODE:
            begin
                kind_next         = KIND_DISPLAY;
                display_page_next = 1'b0;
                draw_page_next    = flip_ok;
                col_next          = '0;
                row_next          = '0;
                row_base_next     = '0;
            end
            default: ;
        endcase
    end

    // Update page and image state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_page_reg <= 1'b0;
            draw_page_reg    <= 1'b0;
            col_reg          <= '0;
            row_reg          <= '0;
            row_base_reg     <= '0;
        end
        else if (advance)
        begin
            display_page_reg <= display_page_next;
            draw_page_reg    <= draw_page_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            row_base_reg     <= row_base_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            byte_reg  <= byte_next;
            start_reg <= start_next;
            done_reg  <= done_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.kind          = kind_reg;
    assign out_ch.vram_address  = addr_reg;
    assign out_ch.write_byte    = byte_reg;
    assign out_ch.display_start = start_reg;
    assign out_ch.image_done    = done_reg;

    // A swizzled write never lands above bit 18
    a_swizzle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == KIND_WRITE) && !linear_mode_reg
        |-> !addr_reg[ADDR_W-1])
        else $error("swizzled address out of range");

    // Image done only marks VRAM writes
    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> (kind_reg == KIND_WRITE))
        else $error("image done on non-write result");

    // Mode start clears the counters and the display page
    a_mode_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (action_reg == ACT_MODE)
        |=> (col_reg == '0) && (row_reg == '0) && (row_base_reg == '0) && !display_page_reg)
        else $error("mode start left state behind");

    // A refused flip leaves the pages alone
    a_flip_refused: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (action_reg == ACT_FLIP) && !flip_ok
        |=> $stable(draw_page_reg) && $stable(display_page_reg))
        else $error("refused flip changed pages");

    // A successful flip shows the page that was being drawn
    a_flip_swap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (action_reg == ACT_FLIP) && flip_ok
        |=> (display_page_reg == $past(draw_page_reg)) && (draw_page_reg != display_page_reg))
        else $error("flip did not swap pages");

endmodule

`default_nettype wire

@@ tb/tb_swizzled_vram_blit_page_flip.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swizzled_vram_blit_page_flip
// Self-checking bench for the VRAM blitter with page flip and mode start.
// A directed table first covers register extremes, flips, refusals, mode
// starts, address wrap, zero and shrunken image sizes. Random phases follow,
// each with its own register setting. Every accepted input beat runs through
// a local model of the page and image counters. Result beats are compared
// field by field, in order, with that model's output.
// ----------------------------------------------------------------------------

module tb;
    import svpf_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned RANDOM_BEATS   = 1325;
    localparam int unsigned MAX_REPORTS    = 100;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  vram_address;
        logic [BYTE_W-1:0]  write_byte;
        logic [START_W-1:0] display_start;
        logic               image_done;
    } blit_result_t;

    typedef struct packed {
        logic                  is_reg_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [ACTION_W-1:0]   act;
        logic [BYTE_W-1:0]     pb;
        logic                  has_lit;
        blit_result_t          lit;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    svpf_in_if  in_ch ();
    svpf_out_if out_ch ();

    swizzled_vram_blit_page_flip uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Local copy of the mode registers
    logic                r_linear;
    logic                r_wide;
    logic [STRIDE_W-1:0] r_stride;
    logic [MROWS_W-1:0]  r_mode_rows;
    logic [IWIDTH_W-1:0] r_img_width;
    logic [IROWS_W-1:0]  r_img_rows;

    // Local copy of the page and image counters
    logic              pg_display;
    logic              pg_draw;
    logic [COL_W-1:0]  col_cnt;
    logic [ROW_W-1:0]  row_cnt;
    logic [ADDR_W-1:0] row_base_q;

    blit_result_t results_due[$];
    stim_row_t    directed_rows[$];

    bit quiet;
    int n_errors;
    int n_beats;
    int n_ignored;
    int n_results;
    int n_images;
    int n_flips;
    int n_refused;
    int n_settings;
    int idle_cycles;

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Apply a beat to the local model and work out the result it causes
    function automatic bit blit_predict(input logic [ACTION_W-1:0] act,
                                        input logic [BYTE_W-1:0] pb,
                                        output blit_result_t res);
        int unsigned frame_bytes;
        int unsigned span;
        int unsigned off;
        bit          flip_ok;
        frame_bytes = r_stride * r_mode_rows;
        flip_ok     = !r_linear && (frame_bytes * 2 <= VRAM_BYTES);
        res         = '0;
        blit_predict = 1'b1;
        case (act)
            ACT_PIXEL:
            begin
                span = r_img_width * (r_wide ? 2 : 1);
                off  = (pg_draw * frame_bytes + row_base_q + col_cnt) & 32'hFFFFF;
                res.kind       = KIND_WRITE;
                res.write_byte = pb;
                if (r_linear)
                    res.vram_address = off[ADDR_W-1:0];
                else
                    res.vram_address = ADDR_W'(((off & 32'h4) << 16)
                                              | ((off & 32'h7fff8) >> 1)
                                              | (off & 32'h3));
                col_cnt = col_cnt + 1'b1;
                if (col_cnt >= span)
                begin
                    col_cnt    = '0;
                    row_base_q = row_base_q + ADDR_W'(r_stride);
                    row_cnt    = row_cnt + 1'b1;
                    if (row_cnt >= r_img_rows)
                    begin
                        row_cnt    = '0;
                        row_base_q = '0;
                        res.image_done = 1'b1;
                    end
                end
            end
            ACT_FLIP:
            begin
                if (!flip_ok)
                    res.kind = KIND_REFUSED;
                else
                begin
                    pg_display = pg_draw;
                    pg_draw    = ~pg_draw;
                    res.kind          = KIND_DISPLAY;
                    res.display_start = START_W'((pg_display * frame_bytes) / 8);
                end
            end
            ACT_MODE:
            begin
                pg_display = 1'b0;
                pg_draw    = flip_ok;
                col_cnt    = '0;
                row_cnt    = '0;
                row_base_q = '0;
                res.kind   = KIND_DISPLAY;
            end
            default:
                blit_predict = 1'b0;
        endcase
    endfunction

    // Table builders for the directed part
    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.is_reg_write = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_beat(input logic [ACTION_W-1:0] act,
                                     input logic [BYTE_W-1:0] pb);
        stim_row_t row;
        row = '0;
        row.act = act;
        row.pb  = pb;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_lit(input logic [ACTION_W-1:0] act,
                                    input logic [BYTE_W-1:0] pb,
                                    input logic [KIND_W-1:0] kind,
                                    input logic [ADDR_W-1:0] addr,
                                    input logic [BYTE_W-1:0] wb,
                                    input logic [START_W-1:0] start,
                                    input logic last);
        stim_row_t row;
        row = '0;
        row.act     = act;
        row.pb      = pb;
        row.has_lit = 1'b1;
        row.lit     = {kind, addr, wb, start, last};
        directed_rows.push_back(row);
    endfunction

    // Write one mode register; the block is idle here
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_LINEAR_MODE: r_linear    = val[0];
            CFG_WIDE_PIXELS: r_wide      = val[0];
            CFG_VRAM_STRIDE: r_stride    = val[STRIDE_W-1:0];
            CFG_MODE_ROWS:   r_mode_rows = val[MROWS_W-1:0];
            CFG_IMAGE_WIDTH: r_img_width = val[IWIDTH_W-1:0];
            CFG_IMAGE_ROWS:  r_img_rows  = val[IROWS_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drop valid, drain every pending result, then let the pipe empty out
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        n_settings++;
    endtask

    // Offer one beat after a random gap and record what it should cause
    task automatic send_beat(input logic [ACTION_W-1:0] act,
                             input logic [BYTE_W-1:0] pb,
                             input logic has_lit,
                             input blit_result_t lit);
        int           gap;
        bit           has_res;
        blit_result_t res;
        gap = quiet ? 0 : $urandom_range(0, 14);
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.pixel_byte <= pb;
        do
            @(posedge clk);
        while (!in_ch.ready);
        has_res = blit_predict(act, pb, res);
        if (has_res)
        begin
            results_due.push_back(has_lit ? lit : res);
            n_beats++;
            if (res.image_done)
                n_images++;
            if (act == ACT_FLIP && res.kind == KIND_DISPLAY)
                n_flips++;
            if (res.kind == KIND_REFUSED)
                n_refused++;
        end
        else
            n_ignored++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            if (n_errors < MAX_REPORTS)
                $display("%0t ns: %s mismatch: expected %0h, got %0h",
                         $time, name, want, got);
            n_errors++;
        end
    endtask

    // Result side: stall ready at random
    initial
    begin : result_ready
        int stall;
        out_ch.ready = 1'b0;
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 14);
            repeat (stall)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // Compare each accepted result beat with the oldest one due
    always @(posedge clk)
    begin : result_check
        blit_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_results++;
            if (results_due.size() == 0)
            begin
                if (n_errors < MAX_REPORTS)
                    $display("%0t ns: result beat with none due: kind %0h address %0h",
                             $time, out_ch.kind, out_ch.vram_address);
                n_errors++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(out_ch.kind));
                check_field("vram_address", 32'(want.vram_address),
                            32'(out_ch.vram_address));
                check_field("write_byte", 32'(want.write_byte), 32'(out_ch.write_byte));
                check_field("display_start", 32'(want.display_start),
                            32'(out_ch.display_start));
                check_field("image_done", 32'(want.image_done), 32'(out_ch.image_done));
            end
        end
    end

    // Watchdog: abort after a long stretch with no beat and no register write
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no progress for %0d cycles, %0d results still due",
                     idle_cycles, results_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence
    initial
    begin : stimulus
        int        n_random;
        int        n_phase;
        bit        in_reg_block;
        stim_row_t row;
        logic [ACTION_W-1:0] act;
        int        pick;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_PIXEL;
        in_ch.pixel_byte = '0;
        quiet            = 1'b0;

        // Register defaults and cleared counters, as after reset
        r_linear    = 1'b0;
        r_wide      = 1'b0;
        r_stride    = RST_VRAM_STRIDE;
        r_mode_rows = RST_MODE_ROWS;
        r_img_width = RST_IMAGE_WIDTH;
        r_img_rows  = RST_IMAGE_ROWS;
        pg_display  = 1'b0;
        pg_draw     = 1'b0;
        col_cnt     = '0;
        row_cnt     = '0;
        row_base_q  = '0;

        // Defaults: first bytes, two flips, mode start, unused action, one more byte
        add_lit(ACT_PIXEL, 8'h00, KIND_WRITE, 20'd0, 8'h00, 16'd0, 1'b0);
        add_lit(ACT_PIXEL, 8'hFF, KIND_WRITE, 20'd1, 8'hFF, 16'd0, 1'b0);
        add_lit(ACT_FLIP, 8'h00, KIND_DISPLAY, 20'd0, 8'h00, 16'd0, 1'b0);
        add_lit(ACT_FLIP, 8'h00, KIND_DISPLAY, 20'd0, 8'h00, 16'd7680, 1'b0);
        add_lit(ACT_MODE, 8'h00, KIND_DISPLAY, 20'd0, 8'h00, 16'd0, 1'b0);
        add_beat(ACT_UNUSED, 8'hFF);
        add_beat(ACT_PIXEL, 8'h81);
        // Linear mode keeps the draw page but refuses to flip
        add_reg(CFG_LINEAR_MODE, 11'd1);
        add_lit(ACT_FLIP, 8'h00, KIND_REFUSED, 20'd0, 8'h00, 16'd0, 1'b0);
        add_beat(ACT_PIXEL, 8'h7E);
        add_lit(ACT_MODE, 8'h00, KIND_DISPLAY, 20'd0, 8'h00, 16'd0, 1'b0);
        // Largest frame: no room for two pages; wide pixels, one-pixel image
        add_reg(CFG_LINEAR_MODE, 11'd0);
        add_reg(CFG_WIDE_PIXELS, 11'd1);
        add_reg(CFG_VRAM_STRIDE, 11'd2047);
        add_reg(CFG_MODE_ROWS, 11'd511);
        add_reg(CFG_IMAGE_WIDTH, 11'd1);
        add_reg(CFG_IMAGE_ROWS, 11'd1);
        add_lit(ACT_FLIP, 8'h00, KIND_REFUSED, 20'd0, 8'h00, 16'd0, 1'b0);
        add_beat(ACT_PIXEL, 8'h11);
        add_beat(ACT_PIXEL, 8'h22);
        // Smallest frame: flips succeed with a start of zero
        add_reg(CFG_WIDE_PIXELS, 11'd0);
        add_reg(CFG_VRAM_STRIDE, 11'd1);
        add_reg(CFG_MODE_ROWS, 11'd1);
        add_reg(CFG_IMAGE_WIDTH, 11'd1023);
        add_reg(CFG_IMAGE_ROWS, 11'd511);
        add_lit(ACT_MODE, 8'h00, KIND_DISPLAY, 20'd0, 8'h00, 16'd0, 1'b0);
        add_lit(ACT_FLIP, 8'h00, KIND_DISPLAY, 20'd0, 8'h00, 16'd0, 1'b0);
        add_lit(ACT_FLIP, 8'h00, KIND_DISPLAY, 20'd0, 8'h00, 16'd0, 1'b0);
        // Grow the frame under draw page one: offsets run past 20 bits
        add_reg(CFG_VRAM_STRIDE, 11'd2047);
        add_reg(CFG_MODE_ROWS, 11'd511);
        add_reg(CFG_IMAGE_WIDTH, 11'd1);
        add_beat(ACT_PIXEL, 8'h44);
        add_beat(ACT_PIXEL, 8'h55);
        add_beat(ACT_PIXEL, 8'h66);
        // Zero image size: every byte ends its image
        add_reg(CFG_IMAGE_WIDTH, 11'd0);
        add_reg(CFG_IMAGE_ROWS, 11'd0);
        add_beat(ACT_PIXEL, 8'h99);
        // Shrink the width while a row is part written
        add_reg(CFG_VRAM_STRIDE, 11'd16);
        add_reg(CFG_MODE_ROWS, 11'd8);
        add_reg(CFG_IMAGE_WIDTH, 11'd8);
        add_reg(CFG_IMAGE_ROWS, 11'd4);
        add_beat(ACT_PIXEL, 8'hA1);
        add_beat(ACT_PIXEL, 8'hA2);
        add_beat(ACT_PIXEL, 8'hA3);
        add_reg(CFG_IMAGE_WIDTH, 11'd2);
        add_beat(ACT_PIXEL, 8'hA4);

        // Hold reset, then release it
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        in_reg_block = 1'b0;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_reg_write)
            begin
                if (!in_reg_block)
                    settle();
                in_reg_block = 1'b1;
                write_reg(row.reg_idx, row.reg_val);
            end
            else
            begin
                in_reg_block = 1'b0;
                send_beat(row.act, row.pb, row.has_lit, row.lit);
            end
        end

        // Random phases, each under a fresh register setting
        n_random = 0;
        while (n_random < RANDOM_BEATS)
        begin
            settle();
            quiet = 1'b0;
            write_reg(CFG_LINEAR_MODE, CFG_DATA_W'($urandom_range(0, 3) == 0));
            write_reg(CFG_WIDE_PIXELS, CFG_DATA_W'($urandom_range(0, 1)));
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_VRAM_STRIDE, CFG_DATA_W'($urandom_range(0, 2047)));
                1:       write_reg(CFG_VRAM_STRIDE, 11'd256);
                2:       write_reg(CFG_VRAM_STRIDE, 11'd2047);
                default: write_reg(CFG_VRAM_STRIDE, CFG_DATA_W'($urandom_range(1, 64)));
            endcase
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_MODE_ROWS, CFG_DATA_W'($urandom_range(0, 511)));
                1:       write_reg(CFG_MODE_ROWS, 11'd240);
                2:       write_reg(CFG_MODE_ROWS, 11'd511);
                default: write_reg(CFG_MODE_ROWS, CFG_DATA_W'($urandom_range(1, 32)));
            endcase
            case ($urandom_range(0, 19))
                0:       write_reg(CFG_IMAGE_WIDTH, 11'd1023);
                1:       write_reg(CFG_IMAGE_WIDTH, 11'd0);
                2:       write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, 1023)));
                default: write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, 10)));
            endcase
            case ($urandom_range(0, 19))
                0:       write_reg(CFG_IMAGE_ROWS, 11'd511);
                1:       write_reg(CFG_IMAGE_ROWS, 11'd0);
                default: write_reg(CFG_IMAGE_ROWS, CFG_DATA_W'($urandom_range(1, 6)));
            endcase
            quiet   = ($urandom_range(0, 3) == 0);
            n_phase = $urandom_range(20, 80);
            // Mostly image bytes, with flips, mode starts and unused codes mixed in
            for (int k = 0; k < n_phase; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 84)
                    act = ACT_PIXEL;
                else if (pick < 90)
                    act = ACT_FLIP;
                else if (pick < 95)
                    act = ACT_MODE;
                else
                    act = ACT_UNUSED;
                send_beat(act, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                if (act != ACT_UNUSED)
                    n_random++;
            end
        end

        // Drain, then give the pipe time to show any stray beat
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (results_due.size() != 0)
        begin
            $display("%0d results still due at the end", results_due.size());
            n_errors++;
        end

        $display("Ran %0d beats with results and %0d unused-code beats under %0d settings;",
                 n_beats, n_ignored, n_settings);
        $display("checked %0d results: %0d images done, %0d flips, %0d refusals, %0d errors.",
                 n_results, n_images, n_flips, n_refused, n_errors);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
